// ===== hw/rtl/vn_pkg.sv =====
// Package for the 2D vector normalizer: payload types, pipeline widths and
// the per-bit trial functions of the square root and unit stages.
// No dependencies.
`timescale 1ns / 1ps
package vn_pkg;

	localparam int RootBits = 16;
	localparam int UnitBits = 15;

	typedef struct packed {
		logic signed [15:0] in_x;
		logic signed [15:0] in_y;
	} in_t;

	typedef struct packed {
		logic signed [15:0] unit_x;
		logic signed [15:0] unit_y;
		logic [15:0]        vec_length;
		logic               is_zero;
	} out_t;

	// Squares and sum of squares with the component signs.
	typedef struct packed {
		logic [31:0] sum;
		logic [30:0] x2;
		logic [30:0] y2;
		logic        nx;
		logic        ny;
	} pay_t;

	// Unit magnitudes and length ahead of the output register.
	typedef struct packed {
		logic [14:0] q_x;
		logic [14:0] q_y;
		logic        nx;
		logic        ny;
		logic [15:0] len;
		logic        zero;
	} unit_res_t;

	// Square of (root | 2^i), given sq = root^2.
	function automatic logic [33:0] sqrt_trial(logic [31:0] sq, logic [15:0] root, int i);
		return {2'b0, sq} + ({18'b0, root} << (i + 1)) + (34'd1 << (2 * i));
	endfunction

	// (q + 2^b)^2 * s, given p = q^2 * s and r = q * s.
	function automatic logic [62:0] unit_trial(logic [58:0] p, logic [45:0] r,
			logic [31:0] s, int b);
		return {4'b0, p} + ({17'b0, r} << (b + 1)) + ({31'b0, s} << (2 * b));
	endfunction

endpackage

// ===== hw/rtl/vector2_normalize_core.sv =====
// Top level of the 2D vector normalizer: floor register, pipeline and output register.
// Depends on vn_pkg, vn_square, vn_isqrt and vn_unit.
//
//   channel   direction   handshake            payload
//   in        into core   in_valid / in_stall  in_data (in_t)
//   out       from core   out_valid / out_stall out_data (out_t)
//   cfg       into core   cfg_we               cfg_wdata (length_floor)
//
// One vector per cycle while the output is not stalled; each result passes through
// 2 square stages, 16 root stages, 15 unit stages and 1 output register.
// The whole pipeline holds while the output register is full and stalled, so
// in_stall follows out_valid and out_stall. Reset empties the pipeline and sets
// the floor to zero.
`timescale 1ns / 1ps
module vector2_normalize_core import vn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic        adv;
	logic [15:0] floor_q;
	logic        sq_valid, rt_valid, un_valid;
	pay_t        sq_pay, rt_pay;
	logic [15:0] rt_root;
	unit_res_t   un_res;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= '0;
		end else if (cfg_we) begin
			floor_q <= cfg_wdata;
		end
	end

	vn_square u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.valid_s2 (sq_valid),
		.pay_s2   (sq_pay)
	);

	vn_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (sq_valid),
		.pay_in    (sq_pay),
		.valid_out (rt_valid),
		.pay_out   (rt_pay),
		.root_out  (rt_root)
	);

	vn_unit u_unit (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.valid_in     (rt_valid),
		.pay_in       (rt_pay),
		.root_in      (rt_root),
		.length_floor (floor_q),
		.valid_out    (un_valid),
		.res_out      (un_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= un_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (un_res.zero) begin
				out_data <= '{unit_x: '0, unit_y: '0, vec_length: '0, is_zero: 1'b1};
			end else begin
				out_data.unit_x     <= un_res.nx ? (16'd0 - {1'b0, un_res.q_x})
					: {1'b0, un_res.q_x};
				out_data.unit_y     <= un_res.ny ? (16'd0 - {1'b0, un_res.q_y})
					: {1'b0, un_res.q_y};
				out_data.vec_length <= un_res.len;
				out_data.is_zero    <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/vn_square.sv =====
// Input stages of the normalizer: component magnitudes, squares and their sum.
// Depends on vn_pkg.
`timescale 1ns / 1ps
module vn_square import vn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  in_t  in_data,
	output logic valid_s2,
	output pay_t pay_s2
);

	logic [16:0] xe, ye, ax, ay;
	logic [33:0] px, py;
	logic        valid_s1;
	logic [30:0] x2_s1, y2_s1;
	logic        nx_s1, ny_s1;

	assign xe = {in_data.in_x[15], in_data.in_x};
	assign ye = {in_data.in_y[15], in_data.in_y};
	assign ax = xe[16] ? (~xe + 17'd1) : xe;
	assign ay = ye[16] ? (~ye + 17'd1) : ye;
	assign px = ax * ax;
	assign py = ay * ay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x2_s1      <= px[30:0];
			y2_s1      <= py[30:0];
			nx_s1      <= xe[16];
			ny_s1      <= ye[16];
			pay_s2.sum <= {1'b0, x2_s1} + {1'b0, y2_s1};
			pay_s2.x2  <= x2_s1;
			pay_s2.y2  <= y2_s1;
			pay_s2.nx  <= nx_s1;
			pay_s2.ny  <= ny_s1;
		end
	end

endmodule

// ===== hw/rtl/vn_isqrt.sv =====
// Bit-per-stage integer square root of the sum of squares, 16 stages.
// Depends on vn_pkg.
`timescale 1ns / 1ps
module vn_isqrt import vn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        valid_in,
	input  pay_t        pay_in,
	output logic        valid_out,
	output pay_t        pay_out,
	output logic [15:0] root_out
);

	logic        valid_s [RootBits];
	pay_t        pay_s   [RootBits];
	logic [15:0] root_s  [RootBits];
	logic [31:0] sq_s    [RootBits];

	for (genvar k = 0; k < RootBits; k++) begin : g_stage
		logic        v_i;
		pay_t        p_i;
		logic [15:0] r_i;
		logic [31:0] sq_i;
		logic [33:0] trial;
		logic        take;

		if (k == 0) begin : g_first
			assign v_i  = valid_in;
			assign p_i  = pay_in;
			assign r_i  = '0;
			assign sq_i = '0;
		end else begin : g_next
			assign v_i  = valid_s[k-1];
			assign p_i  = pay_s[k-1];
			assign r_i  = root_s[k-1];
			assign sq_i = sq_s[k-1];
		end

		assign trial = sqrt_trial(sq_i, r_i, RootBits - 1 - k);
		assign take  = trial <= {2'b0, p_i.sum};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pay_s[k]  <= p_i;
				root_s[k] <= take ? (r_i | (16'd1 << (RootBits - 1 - k))) : r_i;
				sq_s[k]   <= take ? trial[31:0] : sq_i;
			end
		end
	end

	assign valid_out = valid_s[RootBits-1];
	assign pay_out   = pay_s[RootBits-1];
	assign root_out  = root_s[RootBits-1];

endmodule

// ===== hw/rtl/vn_unit.sv =====
// Unit vector stages: one magnitude bit per stage for both components, 15 stages,
// plus the length floor test in the first stage. Depends on vn_pkg.
`timescale 1ns / 1ps
module vn_unit import vn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        valid_in,
	input  pay_t        pay_in,
	input  logic [15:0] root_in,
	input  logic [15:0] length_floor,
	output logic        valid_out,
	output unit_res_t   res_out
);

	logic        valid_s [UnitBits];
	pay_t        pay_s   [UnitBits];
	unit_res_t   res_s   [UnitBits];
	logic [58:0] px_s    [UnitBits];
	logic [58:0] py_s    [UnitBits];
	logic [45:0] rx_s    [UnitBits];
	logic [45:0] ry_s    [UnitBits];

	for (genvar k = 0; k < UnitBits; k++) begin : g_stage
		localparam int B = UnitBits - 1 - k;
		logic        v_i;
		pay_t        p_i;
		unit_res_t   res_i;
		logic [58:0] px_i, py_i;
		logic [45:0] rx_i, ry_i;
		logic [62:0] tx, ty;
		logic        take_x, take_y;
		unit_res_t   res_n;

		if (k == 0) begin : g_first
			assign v_i        = valid_in;
			assign p_i        = pay_in;
			assign res_i.q_x  = '0;
			assign res_i.q_y  = '0;
			assign res_i.nx   = pay_in.nx;
			assign res_i.ny   = pay_in.ny;
			assign res_i.len  = root_in;
			assign res_i.zero = root_in <= length_floor;
			assign px_i       = '0;
			assign py_i       = '0;
			assign rx_i       = '0;
			assign ry_i       = '0;
		end else begin : g_next
			assign v_i   = valid_s[k-1];
			assign p_i   = pay_s[k-1];
			assign res_i = res_s[k-1];
			assign px_i  = px_s[k-1];
			assign py_i  = py_s[k-1];
			assign rx_i  = rx_s[k-1];
			assign ry_i  = ry_s[k-1];
		end

		// The cap at 1.0 needs no test: once q reaches 16384 every lower bit fails.
		assign tx     = unit_trial(px_i, rx_i, p_i.sum, B);
		assign ty     = unit_trial(py_i, ry_i, p_i.sum, B);
		assign take_x = tx <= {4'b0, p_i.x2, 28'b0};
		assign take_y = ty <= {4'b0, p_i.y2, 28'b0};

		always_comb begin
			res_n = res_i;
			if (take_x) begin
				res_n.q_x = res_i.q_x | (15'd1 << B);
			end
			if (take_y) begin
				res_n.q_y = res_i.q_y | (15'd1 << B);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pay_s[k] <= p_i;
				res_s[k] <= res_n;
				px_s[k]  <= take_x ? tx[58:0] : px_i;
				py_s[k]  <= take_y ? ty[58:0] : py_i;
				rx_s[k]  <= take_x ? rx_i + ({14'b0, p_i.sum} << B) : rx_i;
				ry_s[k]  <= take_y ? ry_i + ({14'b0, p_i.sum} << B) : ry_i;
			end
		end
	end

	assign valid_out = valid_s[UnitBits-1];
	assign res_out   = res_s[UnitBits-1];

endmodule

// ===== hw/rtl/vn_checker.sv =====
// Port-level checks for the 2D vector normalizer, bound to the top level.
// Depends on vn_pkg and vector2_normalize_core.
`timescale 1ns / 1ps
module vn_checker import vn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// A result waiting under stall keeps its values.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The input side stalls exactly when a result is held back.
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output stall");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_zero |->
			out_data.unit_x == 16'sd0 && out_data.unit_y == 16'sd0
			&& out_data.vec_length == 16'd0)
		else $error("degenerate result carries nonzero fields");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_zero |->
			out_data.vec_length != 16'd0
			&& out_data.unit_x <= 16'sd16384 && out_data.unit_x >= -16'sd16384
			&& out_data.unit_y <= 16'sd16384 && out_data.unit_y >= -16'sd16384)
		else $error("unit component out of range");

endmodule

bind vector2_normalize_core vn_checker u_vn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
